FILE: rtl/core/paletted_texture_decoder_defines.svh
// Assertion macros used by the paletted texture decoder sequencer.
`ifndef PALETTED_TEXTURE_DECODER_DEFINES_SVH
`define PALETTED_TEXTURE_DECODER_DEFINES_SVH

// Check a condition at every clock edge outside reset.
`define PTD_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Check that a trigger is followed by a condition on the next clock edge.
`define PTD_ASSERT_NEXT(lbl, trig, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) else $error(msg);

`endif

FILE: rtl/core/ptd_pkg.sv
// Shared types and constants for the paletted texture decoder.
`default_nettype none

package ptd_pkg;

  localparam int BYTE_W     = 8;
  localparam int FMT_W      = 4;
  localparam int TOTAL_W    = 23;
  localparam int CFG_DATA_W = 23;
  localparam int SEEN_W     = 11;
  localparam int PADDR_W    = 10;
  localparam int BANKS      = 4;
  localparam int BANK_SEL_W = 2;
  localparam int BANK_DEPTH = 256;
  localparam int BANK_AW    = 8;

  localparam logic [TOTAL_W-1:0] MAX_PIXELS  = 23'd4194304;
  localparam logic [FMT_W-1:0]   FMT_MAX     = 4'd9;
  localparam logic [FMT_W-1:0]   FMT_P8_BASE = 4'd5;

  typedef enum logic [0:0] {
    REG_TEXEL_FORMAT = 1'b0,
    REG_PIXEL_TOTAL  = 1'b1
  } cfg_reg_t;

  typedef enum logic [2:0] {
    KIND_RGB8     = 3'd0,
    KIND_RGBA8    = 3'd1,
    KIND_RGB565   = 3'd2,
    KIND_RGBA4444 = 3'd3,
    KIND_RGBA5551 = 3'd4
  } kind_t;

  // Side information that travels with one palette read.
  typedef struct packed {
    kind_t                 kind;
    logic [BANK_SEL_W-1:0] off;
    logic                  last_of_byte;
    logic                  last_pixel;
  } iss_meta_t;

endpackage

`default_nettype wire

FILE: rtl/core/ptd_ram.sv
// Generic single write port RAM with registered, enabled read.
`default_nettype none

module ptd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  parameter int AW    = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/ptd_sequencer.sv
// Config registers, palette/index byte sequencing, pixel counting and read issue.
`default_nettype none
`include "paletted_texture_decoder_defines.svh"

module ptd_sequencer import ptd_pkg::*; (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             cfg_we,
  input  wire logic [0:0]                       cfg_index,
  input  wire logic [CFG_DATA_W-1:0]            cfg_data,
  input  wire logic                             in_valid,
  output logic                                  in_ready,
  input  wire logic [BYTE_W-1:0]                in_data_byte,
  input  wire logic                             in_final_byte,
  output logic [BANKS-1:0]                      bank_we,
  output logic [BANK_AW-1:0]                    bank_waddr,
  output logic [BYTE_W-1:0]                     bank_wdata,
  output logic [BANKS-1:0][BANK_AW-1:0]         bank_raddr,
  output logic                                  iss_valid,
  input  wire logic                             iss_ready,
  output iss_meta_t                             iss_meta
);

  logic [FMT_W-1:0]   fmt_r;
  logic [TOTAL_W-1:0] total_r;
  logic [SEEN_W-1:0]  seen_r, seen_nxt;
  logic [TOTAL_W-1:0] pe_r, pe_nxt;

  logic              j_valid_r, j_valid_nxt;
  kind_t             j_kind_r;
  logic              j_eight_r;
  logic [BYTE_W-1:0] j_byte_r;
  logic              j_two_r;
  logic              j_pos_r, j_pos_nxt;
  logic              j_lob0_r, j_lp0_r, j_lp1_r;

  logic [FMT_W-1:0]   fmt_c;
  logic               eight;
  kind_t              kind;
  logic [2:0]         esize;
  logic [SEEN_W-1:0]  psize;
  logic               pal_phase;
  logic [TOTAL_W-1:0] limit;
  logic [TOTAL_W:0]   pe1, pe2;
  logic               ended0, ended1, two, ended;
  logic               in_fire, fire, j_last;

  logic [BYTE_W-1:0]     pidx;
  logic [PADDR_W-1:0]    base;
  logic [BANK_AW-1:0]    row0;
  logic [BANK_SEL_W-1:0] off;

  // Format and limit decode.
  always_comb begin
    fmt_c = (fmt_r > FMT_MAX) ? FMT_MAX : fmt_r;
    eight = (fmt_c >= FMT_P8_BASE);
    kind  = kind_t'(eight ? 3'(fmt_c - FMT_P8_BASE) : fmt_c[2:0]);
    case (kind)
      KIND_RGB8:  esize = 3'd3;
      KIND_RGBA8: esize = 3'd4;
      default:    esize = 3'd2;
    endcase
    psize = eight ? {esize, 8'b0} : {4'b0, esize, 4'b0};
    pal_phase = (seen_r < psize);
    if (total_r == '0) begin
      limit = TOTAL_W'(1);
    end else if (total_r > MAX_PIXELS) begin
      limit = MAX_PIXELS;
    end else begin
      limit = total_r;
    end
    pe1    = {1'b0, pe_r} + (TOTAL_W+1)'(1);
    pe2    = {1'b0, pe_r} + (TOTAL_W+1)'(2);
    ended0 = (pe1 >= {1'b0, limit}) || (in_final_byte && eight);
    ended1 = (pe2 >= {1'b0, limit}) || in_final_byte;
    two    = !eight && !ended0;
    ended  = two ? ended1 : ended0;
  end

  assign fire     = j_valid_r && iss_ready;
  assign j_last   = fire && (j_pos_r == j_two_r);
  assign in_ready = !j_valid_r || j_last;
  assign in_fire  = in_valid && in_ready;

  // Palette writes go to bank seen[1:0], row seen[9:2].
  always_comb begin
    for (int b = 0; b < BANKS; b++) begin
      bank_we[b] = in_fire && pal_phase && (seen_r[BANK_SEL_W-1:0] == BANK_SEL_W'(b));
    end
  end
  assign bank_waddr = seen_r[PADDR_W-1:BANK_SEL_W];
  assign bank_wdata = in_data_byte;

  // Counter and job update.
  always_comb begin
    seen_nxt    = seen_r;
    pe_nxt      = pe_r;
    j_valid_nxt = j_valid_r;
    j_pos_nxt   = j_pos_r;
    if (fire) begin
      if (j_last) begin
        j_valid_nxt = 1'b0;
      end else begin
        j_pos_nxt = 1'b1;
      end
    end
    if (in_fire) begin
      if (pal_phase) begin
        seen_nxt = seen_r + SEEN_W'(1);
        if (in_final_byte) begin
          seen_nxt = '0;
          pe_nxt   = '0;
        end
      end else begin
        j_valid_nxt = 1'b1;
        j_pos_nxt   = 1'b0;
        if (ended) begin
          seen_nxt = '0;
          pe_nxt   = '0;
        end else begin
          pe_nxt = two ? pe2[TOTAL_W-1:0] : pe1[TOTAL_W-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fmt_r     <= '0;
      total_r   <= TOTAL_W'(1);
      seen_r    <= '0;
      pe_r      <= '0;
      j_valid_r <= 1'b0;
      j_pos_r   <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_reg_t'(cfg_index))
          REG_TEXEL_FORMAT: fmt_r   <= cfg_data[FMT_W-1:0];
          REG_PIXEL_TOTAL:  total_r <= cfg_data[TOTAL_W-1:0];
          default:          ;
        endcase
      end
      seen_r    <= seen_nxt;
      pe_r      <= pe_nxt;
      j_valid_r <= j_valid_nxt;
      j_pos_r   <= j_pos_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && !pal_phase) begin
      j_kind_r  <= kind;
      j_eight_r <= eight;
      j_byte_r  <= in_data_byte;
      j_two_r   <= two;
      j_lob0_r  <= ended0 || eight;
      j_lp0_r   <= ended0;
      j_lp1_r   <= ended1;
    end
  end

  // Read issue: four consecutive bytes from byte address idx * entry size.
  always_comb begin
    if (j_eight_r) begin
      pidx = j_byte_r;
    end else if (j_pos_r) begin
      pidx = {4'b0, j_byte_r[3:0]};
    end else begin
      pidx = {4'b0, j_byte_r[7:4]};
    end
    case (j_kind_r)
      KIND_RGB8:  base = {2'b0, pidx} + {1'b0, pidx, 1'b0};
      KIND_RGBA8: base = {pidx, 2'b0};
      default:    base = {1'b0, pidx, 1'b0};
    endcase
    row0 = base[PADDR_W-1:BANK_SEL_W];
    off  = base[BANK_SEL_W-1:0];
    for (int b = 0; b < BANKS; b++) begin
      bank_raddr[b] = row0 + BANK_AW'(BANK_SEL_W'(b) < off);
    end
    iss_meta.kind         = j_kind_r;
    iss_meta.off          = off;
    iss_meta.last_of_byte = j_pos_r ? 1'b1 : j_lob0_r;
    iss_meta.last_pixel   = j_pos_r ? j_lp1_r : j_lp0_r;
  end

  assign iss_valid = j_valid_r;

  `PTD_ASSERT_NEXT(a_index_byte_loads_job, in_fire && !pal_phase, j_valid_r,
                   "index byte transfer did not load a job")
  `PTD_ASSERT_ALWAYS(a_pos_within_count, !j_valid_r || !j_pos_r || j_two_r,
                     "second pixel issued for a single-pixel job")
  `PTD_ASSERT_ALWAYS(a_seen_bounded, seen_r <= SEEN_W'(BANKS * BANK_DEPTH),
                     "palette byte count exceeds palette store")
  `PTD_ASSERT_NEXT(a_second_pixel_follows, fire && !j_last, j_valid_r && j_pos_r,
                   "first nibble issued without second pending")

endmodule

`default_nettype wire

FILE: rtl/core/ptd_pixel_out.sv
// Read-data stage, color expansion and output register.
`default_nettype none

module ptd_pixel_out import ptd_pkg::*; (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        iss_valid,
  output logic                             iss_ready,
  input  wire iss_meta_t                   iss_meta,
  input  wire logic [BANKS-1:0][BYTE_W-1:0] bank_rdata,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic [BYTE_W-1:0]                out_red,
  output logic [BYTE_W-1:0]                out_green,
  output logic [BYTE_W-1:0]                out_blue,
  output logic [BYTE_W-1:0]                out_alpha,
  output logic                             out_has_alpha,
  output logic                             out_last_of_byte,
  output logic                             out_last_pixel
);

  logic      r_valid_r;
  iss_meta_t r_meta_r;
  logic      out_valid_r;

  logic o_load, r_move;
  logic [BANKS-1:0][BYTE_W-1:0] bt;
  logic [BANK_SEL_W-1:0] sel;
  logic [BYTE_W-1:0] lo, hi, r_c, g_c, b_c, a_c;
  logic [4:0] r5, b5, g5;
  logic [5:0] g6;
  logic has_a;

  assign o_load    = !out_valid_r || out_ready;
  assign r_move    = r_valid_r && o_load;
  assign iss_ready = !r_valid_r || r_move;

  // Undo the bank rotation, then expand.
  always_comb begin
    for (int j = 0; j < BANKS; j++) begin
      sel   = r_meta_r.off + BANK_SEL_W'(j);
      bt[j] = bank_rdata[sel];
    end
    lo    = bt[0];
    hi    = bt[1];
    r5    = hi[7:3];
    g6    = {hi[2:0], lo[7:5]};
    g5    = {hi[2:0], lo[7:6]};
    b5    = lo[4:0];
    r_c   = bt[0];
    g_c   = bt[1];
    b_c   = bt[2];
    a_c   = 8'hff;
    has_a = 1'b1;
    case (r_meta_r.kind)
      KIND_RGB8: begin
        has_a = 1'b0;
      end
      KIND_RGBA8: begin
        a_c = bt[3];
      end
      KIND_RGB565: begin
        r_c   = {r5, r5[4:2]};
        g_c   = {g6, g6[5:4]};
        b_c   = {b5, b5[4:2]};
        has_a = 1'b0;
      end
      KIND_RGBA4444: begin
        r_c = {hi[7:4], hi[7:4]};
        g_c = {hi[3:0], hi[3:0]};
        b_c = {lo[7:4], lo[7:4]};
        a_c = {lo[3:0], lo[3:0]};
      end
      default: begin
        r_c = {r5, r5[4:2]};
        g_c = {g5, g5[4:2]};
        b_c = {lo[5:1], lo[5:3]};
        a_c = {BYTE_W{lo[0]}};
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      r_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (iss_valid && iss_ready) begin
        r_valid_r <= 1'b1;
      end else if (r_move) begin
        r_valid_r <= 1'b0;
      end
      if (o_load) begin
        out_valid_r <= r_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (iss_valid && iss_ready) begin
      r_meta_r <= iss_meta;
    end
    if (r_move) begin
      out_red          <= r_c;
      out_green        <= g_c;
      out_blue         <= b_c;
      out_alpha        <= a_c;
      out_has_alpha    <= has_a;
      out_last_of_byte <= r_meta_r.last_of_byte;
      out_last_pixel   <= r_meta_r.last_pixel;
    end
  end

  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

FILE: rtl/core/paletted_texture_decoder.sv
// Top level of the paletted texture decoder.
`default_nettype none

// Paletted texture decoder. Bytes arrive on the in_ channel: first the palette
// (16 or 256 entries of 2, 3 or 4 bytes, as texel_format selects), then index
// bytes. Each index byte gives one pixel (PALETTE8) or two pixels, high nibble
// first (PALETTE4); every pixel leaves on the out_ channel as 8-bit RGBA with
// last_of_byte and last_pixel flags. The image ends after pixel_total pixels
// or on a byte marked final, after which the next bytes form a new palette.
// Palette bytes and PALETTE8 index bytes are taken back to back unless the
// output stalls; a PALETTE4 index byte is held until each of its pixels has
// issued its single palette read; four byte-wide banks fetch any entry in one
// read. Each pixel passes the job, bank read and output registers. The palette
// store needs no clearing after reset. Write configuration only while idle.

module paletted_texture_decoder import ptd_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_we,
  input  wire logic [0:0]            cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic [BYTE_W-1:0]     in_data_byte,
  input  wire logic                  in_final_byte,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic [BYTE_W-1:0]          out_red,
  output logic [BYTE_W-1:0]          out_green,
  output logic [BYTE_W-1:0]          out_blue,
  output logic [BYTE_W-1:0]          out_alpha,
  output logic                       out_has_alpha,
  output logic                       out_last_of_byte,
  output logic                       out_last_pixel
);

  logic [BANKS-1:0]                 bank_we;
  logic [BANK_AW-1:0]               bank_waddr;
  logic [BYTE_W-1:0]                bank_wdata;
  logic [BANKS-1:0][BANK_AW-1:0]    bank_raddr;
  logic [BANKS-1:0][BYTE_W-1:0]     bank_rdata;
  logic                             iss_valid, iss_ready;
  iss_meta_t                        iss_meta;

  // Sequencer: hold config, count palette bytes and pixels, issue reads.
  ptd_sequencer u_seq (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_data_byte  (in_data_byte),
    .in_final_byte (in_final_byte),
    .bank_we       (bank_we),
    .bank_waddr    (bank_waddr),
    .bank_wdata    (bank_wdata),
    .bank_raddr    (bank_raddr),
    .iss_valid     (iss_valid),
    .iss_ready     (iss_ready),
    .iss_meta      (iss_meta)
  );

  // Palette banks: byte address a lives in bank a[1:0], row a[9:2]. A read
  // only advances on an issue transfer, so stalled data holds in the bank.
  for (genvar b = 0; b < BANKS; b++) begin : g_bank
    ptd_ram #(
      .WIDTH (BYTE_W),
      .DEPTH (BANK_DEPTH)
    ) u_bank (
      .clk   (clk),
      .we    (bank_we[b]),
      .waddr (bank_waddr),
      .wdata (bank_wdata),
      .re    (iss_valid && iss_ready),
      .raddr (bank_raddr[b]),
      .rdata (bank_rdata[b])
    );
  end

  // Output side: expand colors into the output register.
  ptd_pixel_out u_out (
    .clk              (clk),
    .rst_n            (rst_n),
    .iss_valid        (iss_valid),
    .iss_ready        (iss_ready),
    .iss_meta         (iss_meta),
    .bank_rdata       (bank_rdata),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_red          (out_red),
    .out_green        (out_green),
    .out_blue         (out_blue),
    .out_alpha        (out_alpha),
    .out_has_alpha    (out_has_alpha),
    .out_last_of_byte (out_last_of_byte),
    .out_last_pixel   (out_last_pixel)
  );

endmodule

`default_nettype wire

FILE: dv/tb_texel_pkg.sv
// Pixel scoreboard for the paletted texture decoder testbench.
package tb_texel_pkg;

  import ptd_pkg::*;

  localparam int unsigned STORE_DEPTH = 1024;
  localparam int          REPORT_CAP  = 200;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
    logic       has_alpha;
    logic       last_of_byte;
    logic       last_pixel;
  } pixel_t;

  class texel_scoreboard;
    logic [FMT_W-1:0]   fmt_reg;
    logic [TOTAL_W-1:0] total_reg;
    logic [7:0]         palette [STORE_DEPTH];
    int unsigned        pal_count;
    int unsigned        pix_count;
    bit                 image_done;
    pixel_t             pixels_due [$];
    int                 mismatches;
    int                 checked;

    function new();
      fmt_reg    = '0;
      total_reg  = 23'd1;
      pal_count  = 0;
      pix_count  = 0;
      image_done = 1'b0;
      mismatches = 0;
      checked    = 0;
      foreach (palette[i]) palette[i] = 8'h00;
    endfunction

    function void set_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] d);
      case (idx)
        REG_TEXEL_FORMAT: fmt_reg = d[FMT_W-1:0];
        REG_PIXEL_TOTAL:  total_reg = d[TOTAL_W-1:0];
        default: ;
      endcase
    endfunction

    // Codes above nine behave as nine.
    function logic [FMT_W-1:0] eff_fmt();
      return (fmt_reg > FMT_MAX) ? FMT_MAX : fmt_reg;
    endfunction

    function bit eight_bit();
      return eff_fmt() >= FMT_P8_BASE;
    endfunction

    function kind_t active_kind();
      return kind_t'(3'(eight_bit() ? eff_fmt() - FMT_P8_BASE : eff_fmt()));
    endfunction

    function int unsigned palette_len();
      int unsigned esize;
      case (active_kind())
        KIND_RGB8:  esize = 3;
        KIND_RGBA8: esize = 4;
        default:    esize = 2;
      endcase
      return (eight_bit() ? 256 : 16) * esize;
    endfunction

    function bit in_palette();
      return pal_count < palette_len();
    endfunction

    function int pending();
      return pixels_due.size();
    endfunction

    function logic [7:0] entry_byte(int unsigned a);
      return palette[a % STORE_DEPTH];
    endfunction

    // Look up one palette entry and widen it to 8-bit RGBA.
    function pixel_t shade_texel(kind_t kind, logic [7:0] idx);
      pixel_t     px;
      logic [7:0] lo;
      logic [7:0] hi;
      logic [4:0] r5;
      logic [5:0] g6;
      logic [4:0] g5;
      logic [4:0] b5;
      px       = '0;
      px.alpha = 8'hff;
      lo       = entry_byte(idx * 2);
      hi       = entry_byte(idx * 2 + 1);
      case (kind)
        KIND_RGB8: begin
          px.red   = entry_byte(idx * 3);
          px.green = entry_byte(idx * 3 + 1);
          px.blue  = entry_byte(idx * 3 + 2);
        end
        KIND_RGBA8: begin
          px.red   = entry_byte(idx * 4);
          px.green = entry_byte(idx * 4 + 1);
          px.blue  = entry_byte(idx * 4 + 2);
          px.alpha = entry_byte(idx * 4 + 3);
        end
        KIND_RGB565: begin
          r5       = hi[7:3];
          g6       = {hi[2:0], lo[7:5]};
          b5       = lo[4:0];
          px.red   = {r5, r5[4:2]};
          px.green = {g6, g6[5:4]};
          px.blue  = {b5, b5[4:2]};
        end
        KIND_RGBA4444: begin
          px.red   = {hi[7:4], hi[7:4]};
          px.green = {hi[3:0], hi[3:0]};
          px.blue  = {lo[7:4], lo[7:4]};
          px.alpha = {lo[3:0], lo[3:0]};
        end
        default: begin
          r5       = hi[7:3];
          g5       = {hi[2:0], lo[7:6]};
          b5       = lo[5:1];
          px.red   = {r5, r5[4:2]};
          px.green = {g5, g5[4:2]};
          px.blue  = {b5, b5[4:2]};
          px.alpha = {8{lo[0]}};
        end
      endcase
      px.has_alpha = kind inside {KIND_RGBA8, KIND_RGBA4444, KIND_RGBA5551};
      return px;
    endfunction

    function void restart();
      pal_count  = 0;
      pix_count  = 0;
      image_done = 1'b1;
    endfunction

    // Note one accepted byte and queue the pixels it yields.
    function void note_byte(logic [7:0] b, logic fin);
      logic [7:0]  nib [2];
      int          avail;
      bit          ended;
      pixel_t      px;
      int unsigned lim;
      if (in_palette()) begin
        palette[pal_count % STORE_DEPTH] = b;
        pal_count++;
        if (fin) restart();
        return;
      end
      lim = (total_reg == 0) ? 1 : ((total_reg > MAX_PIXELS) ? MAX_PIXELS : total_reg);
      if (eight_bit()) begin
        nib[0] = b;
        nib[1] = 8'h00;
        avail  = 1;
      end else begin
        nib[0] = {4'h0, b[7:4]};
        nib[1] = {4'h0, b[3:0]};
        avail  = 2;
      end
      ended = 1'b0;
      for (int k = 0; k < avail && !ended; k++) begin
        px = shade_texel(active_kind(), nib[k]);
        pix_count++;
        ended           = (pix_count >= lim) || (fin && k == avail - 1);
        px.last_of_byte = ended || (k == avail - 1);
        px.last_pixel   = ended;
        pixels_due.push_back(px);
      end
      if (ended) restart();
    endfunction

    task report(string msg);
      mismatches++;
      if (mismatches <= REPORT_CAP) $display("MISMATCH: %s", msg);
    endtask

    task check_pixel(pixel_t got);
      pixel_t     want;
      logic [7:0] seen [7];
      logic [7:0] due  [7];
      string      label [7];
      if (pixels_due.size() == 0) begin
        report($sformatf("pixel %0d arrived with none due: %h", checked, got));
        checked++;
        return;
      end
      want  = pixels_due.pop_front();
      label = '{"red", "green", "blue", "alpha", "has_alpha", "last_of_byte", "last_pixel"};
      seen  = '{got.red, got.green, got.blue, got.alpha, {7'd0, got.has_alpha},
                {7'd0, got.last_of_byte}, {7'd0, got.last_pixel}};
      due   = '{want.red, want.green, want.blue, want.alpha, {7'd0, want.has_alpha},
                {7'd0, want.last_of_byte}, {7'd0, want.last_pixel}};
      for (int f = 0; f < 7; f++) begin
        if (seen[f] !== due[f])
          report($sformatf("pixel %0d %s: got %h want %h", checked, label[f], seen[f], due[f]));
      end
      checked++;
    endtask
  endclass

endpackage

FILE: dv/tb_paletted_texture_decoder.sv
// Testbench top for the paletted texture decoder: stimulus, handshakes and the final verdict.
module tb_paletted_texture_decoder;
  timeunit 1ns;
  timeprecision 1ps;

  import ptd_pkg::*;
  import tb_texel_pkg::*;

  localparam int IDLE_PCT      = 13;
  localparam int SETTLE_CYCLES = 8;       // leave margin for the pipeline to drain
  localparam int RANDOM_ITEMS  = 1250;
  localparam int CYCLE_LIMIT   = 400000;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [0:0]            cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  in_valid;
  logic                  in_ready;
  logic [BYTE_W-1:0]     in_data_byte;
  logic                  in_final_byte;
  logic                  out_valid;
  logic                  out_ready;
  logic [BYTE_W-1:0]     out_red;
  logic [BYTE_W-1:0]     out_green;
  logic [BYTE_W-1:0]     out_blue;
  logic [BYTE_W-1:0]     out_alpha;
  logic                  out_has_alpha;
  logic                  out_last_of_byte;
  logic                  out_last_pixel;

  texel_scoreboard sb;
  bit              in_fire;          // input transfer seen at the last rising edge
  int              in_idle_pct;
  int              out_idle_pct;
  int              bytes_sent;
  int              cycle_count;

  paletted_texture_decoder i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_data_byte     (in_data_byte),
    .in_final_byte    (in_final_byte),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_red          (out_red),
    .out_green        (out_green),
    .out_blue         (out_blue),
    .out_alpha        (out_alpha),
    .out_has_alpha    (out_has_alpha),
    .out_last_of_byte (out_last_of_byte),
    .out_last_pixel   (out_last_pixel)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Sample both channels at the rising edge. Outputs are checked before the
  // input of the same edge is noted; that byte cannot show up yet, as the output is registered.
  always @(posedge clk) begin
    pixel_t got;
    got.red          = out_red;
    got.green        = out_green;
    got.blue         = out_blue;
    got.alpha        = out_alpha;
    got.has_alpha    = out_has_alpha;
    got.last_of_byte = out_last_of_byte;
    got.last_pixel   = out_last_pixel;
    if (rst_n && out_valid && out_ready) sb.check_pixel(got);
    in_fire = rst_n && in_valid && in_ready;
    if (in_fire) sb.note_byte(in_data_byte, in_final_byte);
  end

  // Receiver: stall at random on the falling edge.
  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= out_idle_pct);
  end

  // Watchdog: stop a hung run.
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("tb_paletted_texture_decoder: done, errors");
    $finish;
  end

  function automatic bit skip_cycle(int pct);
    return $urandom_range(99) < pct;
  endfunction

  function automatic logic [FMT_W-1:0] fmt_code(bit p8, kind_t k);
    return (p8 ? FMT_P8_BASE : 4'd0) + 4'(k);
  endfunction

  // Offer one byte and hold it until the transfer. Returns on the falling
  // edge just after the transfer with valid still high, so the next call
  // either replaces the payload or drops valid, never both.
  task automatic send_byte(input logic [7:0] b, input logic fin);
    while (skip_cycle(in_idle_pct)) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid      <= 1'b1;
    in_data_byte  <= b;
    in_final_byte <= fin;
    @(negedge clk);
    while (!in_fire) @(negedge clk);
    bytes_sent++;
  endtask

  // Drop valid, wait until every due pixel has left, then give the pipeline
  // SETTLE_CYCLES of idle time in case the last byte produced nothing.
  task automatic settle();
    in_valid <= 1'b0;
    @(negedge clk);
    while (sb.pending() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Write one or both registers on consecutive cycles; call only when settled.
  task automatic program_regs(input bit set_fmt, input logic [FMT_W-1:0] fmt,
                              input bit set_total, input logic [TOTAL_W-1:0] total);
    logic [CFG_DATA_W-1:0] word;
    if (set_fmt) begin
      // Fill the unused upper bits with noise; only the low nibble counts.
      word      = {19'($urandom), fmt};
      cfg_we    <= 1'b1;
      cfg_index <= REG_TEXEL_FORMAT;
      cfg_data  <= word;
      sb.set_reg(REG_TEXEL_FORMAT, word);
      @(negedge clk);
    end
    if (set_total) begin
      cfg_we    <= 1'b1;
      cfg_index <= REG_PIXEL_TOTAL;
      cfg_data  <= total;
      sb.set_reg(REG_PIXEL_TOTAL, total);
      @(negedge clk);
    end
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic fill_palette();
    while (sb.in_palette()) send_byte(8'($urandom_range(255)), 1'b0);
  endtask

  task automatic send_index_run(input int n, input bit close);
    for (int k = 0; k < n; k++) send_byte(8'($urandom_range(255)), close && (k == n - 1));
  endtask

  // Short directed pass on PALETTE4: extremes of the entries and nibbles,
  // a palette cut short by a final byte, format changes while the image is
  // open (growing the palette twice), a total already passed, and a final
  // byte in the index data.
  task automatic run_directed();
    settle();
    program_regs(1'b1, fmt_code(1'b0, KIND_RGBA4444), 1'b1, 23'h7fffff);
    // Final byte inside the palette: stored, nothing out, restart.
    send_byte(8'h00, 1'b0);
    send_byte(8'hff, 1'b0);
    send_byte(8'h3c, 1'b1);
    settle();
    // Entry 0 all zeros, entry 15 all ones, alternating pattern in between.
    for (int k = 0; k < 32; k++) begin
      send_byte((k < 2) ? 8'h00 : (k >= 30) ? 8'hff :
                (k % 2) ? 8'ha5 : 8'($urandom_range(255)), 1'b0);
    end
    send_byte(8'h0f, 1'b0);
    send_byte(8'hf0, 1'b0);
    settle();
    program_regs(1'b1, fmt_code(1'b0, KIND_RGB565), 1'b0, '0);
    send_byte(8'hff, 1'b0);
    send_byte(8'h00, 1'b0);
    settle();
    program_regs(1'b1, fmt_code(1'b0, KIND_RGBA5551), 1'b0, '0);
    send_byte(8'h1e, 1'b0);
    send_byte(8'he1, 1'b0);
    // Larger entries: the next bytes extend the palette before indexing resumes.
    settle();
    program_regs(1'b1, fmt_code(1'b0, KIND_RGB8), 1'b0, '0);
    fill_palette();
    send_byte(8'h0f, 1'b0);
    settle();
    program_regs(1'b1, fmt_code(1'b0, KIND_RGBA8), 1'b0, '0);
    fill_palette();
    send_byte(8'h3c, 1'b0);
    // Zero total acts as one and the count is already past it: the high
    // nibble of the next byte ends the image, the low nibble is dropped.
    settle();
    program_regs(1'b0, '0, 1'b1, 23'd0);
    send_byte(8'hf0, 1'b0);
    // Maximum total, image closed by a final byte in the index data.
    settle();
    program_regs(1'b1, fmt_code(1'b0, KIND_RGB565), 1'b1, MAX_PIXELS);
    fill_palette();
    send_byte(8'h12, 1'b1);
  endtask

  // One PALETTE8 image that walks every PALETTE8 kind: start with a 512-byte
  // palette, switch kinds while open, and grow the palette to 768 and 1024.
  task automatic run_palette8_tour();
    settle();
    program_regs(1'b1, fmt_code(1'b1, KIND_RGB565), 1'b1, 23'h7fffff);
    sb.image_done = 1'b0;
    fill_palette();
    send_index_run(12, 1'b0);
    settle();
    program_regs(1'b1, fmt_code(1'b1, KIND_RGBA4444), 1'b0, '0);
    send_index_run(12, 1'b0);
    settle();
    // Codes above nine fold onto PALETTE8 5551.
    program_regs(1'b1, 4'($urandom_range(10, 15)), 1'b0, '0);
    send_index_run(12, 1'b0);
    settle();
    program_regs(1'b1, fmt_code(1'b1, KIND_RGB8), 1'b0, '0);
    fill_palette();
    send_index_run(12, 1'b0);
    settle();
    program_regs(1'b1, fmt_code(1'b1, KIND_RGBA8), 1'b0, '0);
    fill_palette();
    send_index_run(12, 1'b1);
  endtask

  // Drive one image: palette bytes while the palette is open, then index
  // bytes until the image ends. Optionally cut the palette short, close with
  // an early final byte, or retune a register once mid-image.
  task automatic feed_image(input int abort_at, input int fin_at, input int retune_at);
    int n_pal;
    int n_idx;
    bit retuned;
    n_pal         = 0;
    n_idx         = 0;
    retuned       = 1'b0;
    sb.image_done = 1'b0;
    while (!sb.image_done) begin
      if (!sb.in_palette() && n_idx == retune_at && !retuned) begin
        settle();
        retuned = 1'b1;
        if ($urandom_range(1)) program_regs(1'b1, 4'($urandom_range(0, 4)), 1'b0, '0);
        else program_regs(1'b0, '0, 1'b1, 23'($urandom_range(0, 40)));
      end else if (sb.in_palette()) begin
        send_byte(8'($urandom_range(255)), n_pal == abort_at);
        n_pal++;
      end else begin
        send_byte(8'($urandom_range(255)), n_idx == fin_at);
        n_idx++;
      end
    end
  endtask

  task automatic run_random_images();
    int                 start;
    int                 img;
    int                 p8_images;
    logic [FMT_W-1:0]   fmt;
    logic [TOTAL_W-1:0] total;
    int                 abort_at;
    int                 fin_at;
    int                 retune_at;
    start     = bytes_sent;
    img       = 0;
    p8_images = 0;
    while (bytes_sent - start < RANDOM_ITEMS) begin
      // Hold a quiet stretch with no idling on either side.
      in_idle_pct  = (img >= 4 && img < 8) ? 0 : IDLE_PCT;
      out_idle_pct = in_idle_pct;
      abort_at     = ($urandom_range(9) == 0) ? $urandom_range(0, 63) : -1;
      retune_at    = -1;
      if (p8_images < 2 && $urandom_range(11) == 0) begin
        p8_images++;
        fmt   = 4'($urandom_range(5, 15));
        total = 23'($urandom_range(1, 60));
      end else begin
        fmt = 4'($urandom_range(0, 4));
        case ($urandom_range(9))
          0:       total = 23'd1;
          1:       total = 23'd0;
          2:       total = MAX_PIXELS;
          3:       total = 23'($urandom_range(23'h7fffff, 23'd4194305));
          4:       total = 23'h7fffff;
          default: total = 23'($urandom_range(2, 40));
        endcase
        if ($urandom_range(7) == 0) retune_at = $urandom_range(0, 10);
      end
      // Huge totals end on a final byte unless retuned; small ones sometimes early.
      if (total > 64) fin_at = $urandom_range(0, 29);
      else if ($urandom_range(3) == 0) fin_at = $urandom_range(0, 20);
      else fin_at = -1;
      settle();
      program_regs(1'b1, fmt, 1'b1, total);
      feed_image(abort_at, fin_at, retune_at);
      img++;
    end
  endtask

  initial begin
    sb            = new();
    in_fire       = 1'b0;
    in_idle_pct   = IDLE_PCT;
    out_idle_pct  = IDLE_PCT;
    bytes_sent    = 0;
    rst_n         = 1'b0;
    cfg_we        = 1'b0;
    cfg_index     = REG_TEXEL_FORMAT;
    cfg_data      = '0;
    in_valid      = 1'b0;
    in_data_byte  = '0;
    in_final_byte = 1'b0;
    out_ready     = 1'b0;
    // Hold reset, then release it on a falling edge.
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    run_directed();
    run_palette8_tour();
    run_random_images();
    settle();
    if (sb.mismatches == 0) begin
      $display("tb_paletted_texture_decoder: done, clean");
    end else begin
      $display("tb_paletted_texture_decoder: done, errors");
    end
    $finish;
  end

endmodule

FILE: paletted_texture_decoder.f
+incdir+rtl/core
rtl/core/ptd_pkg.sv
rtl/core/ptd_ram.sv
rtl/core/ptd_sequencer.sv
rtl/core/ptd_pixel_out.sv
rtl/core/paletted_texture_decoder.sv
dv/tb_texel_pkg.sv
dv/tb_paletted_texture_decoder.sv
